[design/ppu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the packed pixel unpacker.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int WORD_BITS  = 32;
    localparam int COL_BITS   = 13;
    localparam int ROW_BITS   = 12;
    localparam int CFG_BITS   = 13;
    localparam int ADDR_BITS  = 3;
    localparam int LG_MAX     = 5;

    // register indexes of the configuration port
    localparam logic [ADDR_BITS-1:0] CFG_BPP_LOG2    = 3'd0;
    localparam logic [ADDR_BITS-1:0] CFG_PIXEL_DEPTH = 3'd1;
    localparam logic [ADDR_BITS-1:0] CFG_SCAN_WIDTH  = 3'd2;
    localparam logic [ADDR_BITS-1:0] CFG_FIRST_COL   = 3'd3;
    localparam logic [ADDR_BITS-1:0] CFG_END_COL     = 3'd4;
    localparam logic [ADDR_BITS-1:0] CFG_FIRST_ROW   = 3'd5;
    localparam logic [ADDR_BITS-1:0] CFG_END_ROW     = 3'd6;

    // decoded configuration; the user must keep it stable while items are in flight, the block does not enforce it
    typedef struct packed {
        logic [2:0]           lg;        // clipped to LG_MAX
        logic [WORD_BITS-1:0] mask;
        logic [COL_BITS-1:0]  width;     // zero and oversize already fixed up
        logic [CFG_BITS-1:0]  first_col;
        logic [CFG_BITS-1:0]  end_col;
        logic [CFG_BITS-1:0]  first_row;
        logic [CFG_BITS-1:0]  end_row;
    } t_cfg;

    // one classified word waiting for the slot emitter
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [COL_BITS-1:0]  col_base;
        logic [ROW_BITS-1:0]  row;
        logic                 row_in;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry data;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry data;
    } t_head;

endpackage

[design/ppu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_front
// Accepts source words, tags them with start column, row and row window
// flag, and advances the scanline position counters.
// ----------------------------------------------------------------------------
module ppu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppu_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    input  logic [ppu_pkg::WORD_BITS-1:0] i_word,
    input  logic                          i_space,
    output logic                          o_ready,
    output ppu_pkg::t_push                o_push
);

    logic [ppu_pkg::COL_BITS-1:0] r_col;
    logic [ppu_pkg::ROW_BITS-1:0] r_row;
    logic [ppu_pkg::COL_BITS-1:0] n_col;
    logic [ppu_pkg::ROW_BITS-1:0] n_row;
    logic [5:0]                   slots;
    logic [ppu_pkg::COL_BITS:0]   col_sum;
    logic                         accept;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign slots   = 6'(6'd32 >> i_cfg.lg);
    assign col_sum = {1'b0, r_col} + {8'd0, slots};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_sum >= {1'b0, i_cfg.width}) begin
                n_col = '0;
                n_row = r_row + 12'd1;
            end else begin
                n_col = col_sum[ppu_pkg::COL_BITS-1:0];
            end
        end
    end

    always_comb begin
        o_push.push          = accept;
        o_push.data.word     = i_word;
        o_push.data.col_base = r_col;
        o_push.data.row      = r_row;
        o_push.data.row_in   = ({1'b0, r_row} >= i_cfg.first_row)
                            && ({1'b0, r_row} < i_cfg.end_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[design/ppu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_queue
// Two-entry queue of classified words between front and slot emitter.
// ----------------------------------------------------------------------------
module ppu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppu_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_space,
    output ppu_pkg::t_head o_head
);

    ppu_pkg::t_entry r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            do_pop;

    assign o_space      = (r_count != 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.data  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push.push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/ppu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_back
// Walks the queue head slots, one per cycle unless the output stalls, into the
// output register: extracts and masks the pixel, computes column, keep flag.
// ----------------------------------------------------------------------------
module ppu_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppu_pkg::t_cfg                 i_cfg,
    input  ppu_pkg::t_head                i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ppu_pkg::WORD_BITS-1:0] o_pixel,
    output logic [ppu_pkg::COL_BITS-1:0]  o_col,
    output logic [ppu_pkg::ROW_BITS-1:0]  o_row,
    output logic                          o_keep,
    output logic                          o_last
);

    logic [4:0]                   r_k;
    logic                         r_valid;
    logic [ppu_pkg::WORD_BITS-1:0] r_pixel;
    logic [ppu_pkg::COL_BITS-1:0] r_col;
    logic [ppu_pkg::ROW_BITS-1:0] r_row;
    logic                         r_keep;
    logic                         r_last;

    logic                         load;
    logic [4:0]                   k_last;
    logic [4:0]                   shift;
    logic                         is_last;
    logic [ppu_pkg::COL_BITS:0]   col_full;
    logic                         keep;

    assign load     = i_head.valid && (!r_valid || i_ready);
    assign k_last   = 5'd31 >> i_cfg.lg;
    assign shift    = 5'(r_k << i_cfg.lg);
    assign is_last  = (r_k == k_last);
    assign col_full = {1'b0, i_head.data.col_base} + {9'd0, r_k};
    assign keep     = i_head.data.row_in
                   && (col_full < {1'b0, i_cfg.width})
                   && (col_full >= {1'b0, i_cfg.first_col})
                   && (col_full < {1'b0, i_cfg.end_col});
    assign o_pop    = load && is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= (i_head.data.word >> shift) & i_cfg.mask;
            r_col   <= col_full[ppu_pkg::COL_BITS-1:0];
            r_row   <= i_head.data.row;
            r_keep  <= keep;
            r_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k <= is_last ? 5'd0 : r_k + 5'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_keep  = r_keep;
    assign o_last  = r_last;

endmodule

[design/packed_pixel_unpacker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_pixel_unpacker
// Splits packed scanline words into pixel slots with column, row and
// window keep flag.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s        in   i_s_tvalid/o_s_tready  tdata: source_word
//  m        out  o_m_tvalid/i_m_tready  tdata: pixel, col, row; tlast; tuser keep
//  cfg      in   i_cfg_valid/o_cfg_ready addr: register index, data: value
//
// Each word gives 32 >> min(bpp_log2, 5) results, one per cycle from the slot
// emitter unless the output stalls; at 32 bpp one word per cycle is sustained.
// A two-entry queue lets words come in while the emitter works or the output
// stalls. Reset is synchronous; registers and counters come up at once, no
// clearing pass. Configuration is always ready.
// ----------------------------------------------------------------------------
module packed_pixel_unpacker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] source_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] pixel_value, [44:32] src_col,
                                     // [56:45] src_row, [63:57] zero
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // [0] keep
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_data
);

    localparam logic [12:0] MAX_W13 = (MAX_WIDTH > 8191) ? 13'h1FFF : 13'(MAX_WIDTH);

    logic [2:0]  r_bpp_log2;
    logic [5:0]  r_depth;
    logic [12:0] r_width;
    logic [12:0] r_first_col;
    logic [12:0] r_end_col;
    logic [12:0] r_first_row;
    logic [12:0] r_end_row;

    ppu_pkg::t_cfg  cfg;
    ppu_pkg::t_push push;
    ppu_pkg::t_head head;
    logic           space;
    logic           pop;
    logic [5:0]     bpp;
    logic [5:0]     keep_bits;
    logic [32:0]    mask33;

    logic [31:0]    pixel;
    logic [12:0]    col;
    logic [11:0]    row;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp_log2  <= 3'd5;
            r_depth     <= 6'd24;
            r_width     <= 13'd1;
            r_first_col <= '0;
            r_end_col   <= '0;
            r_first_row <= '0;
            r_end_row   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                ppu_pkg::CFG_BPP_LOG2:    r_bpp_log2  <= i_cfg_data[2:0];
                ppu_pkg::CFG_PIXEL_DEPTH: r_depth     <= i_cfg_data[5:0];
                ppu_pkg::CFG_SCAN_WIDTH:  r_width     <= i_cfg_data;
                ppu_pkg::CFG_FIRST_COL:   r_first_col <= i_cfg_data;
                ppu_pkg::CFG_END_COL:     r_end_col   <= i_cfg_data;
                ppu_pkg::CFG_FIRST_ROW:   r_first_row <= i_cfg_data;
                ppu_pkg::CFG_END_ROW:     r_end_row   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // codes above 5 act as 32 bpp; slot mask never spans beyond the slot
    always_comb begin
        cfg.lg    = (r_bpp_log2 > 3'(ppu_pkg::LG_MAX)) ? 3'(ppu_pkg::LG_MAX) : r_bpp_log2;
        bpp       = 6'(6'd1 << cfg.lg);
        keep_bits = (r_depth < bpp) ? r_depth : bpp;
        mask33    = (33'd1 << keep_bits) - 33'd1;
        cfg.mask  = mask33[31:0];
        if (r_width == 13'd0) begin
            cfg.width = 13'd1;
        end else if (r_width > MAX_W13) begin
            cfg.width = MAX_W13;
        end else begin
            cfg.width = r_width;
        end
        cfg.first_col = r_first_col;
        cfg.end_col   = r_end_col;
        cfg.first_row = r_first_row;
        cfg.end_row   = r_end_row;
    end

    ppu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_s_tvalid),
        .i_word  (i_s_tdata),
        .i_space (space),
        .o_ready (o_s_tready),
        .o_push  (push)
    );

    ppu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_space (space),
        .o_head  (head)
    );

    ppu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_pixel (pixel),
        .o_col   (col),
        .o_row   (row),
        .o_keep  (o_m_tuser),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, row, col, pixel};

endmodule

[design/ppu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_checker
// Port-level checks of the packed pixel unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module ppu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // slots of one word come out back to back, same row, next column
    a_word_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid
            && (o_m_tdata[56:45] == $past(o_m_tdata[56:45]))
            && (o_m_tdata[44:32] == $past(o_m_tdata[44:32]) + 13'd1))
        else $error("slot run of a word broken");

    // input only backs up when results are pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind packed_pixel_unpacker ppu_checker u_ppu_checker (.*);
